/* rtl/ecn_path_validator_defines.svh */
// ----------------------------------------------------------------------------
// ecn path validator assertion macros
// shared concurrent assertion forms, sampled on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef ECN_PATH_VALIDATOR_DEFINES_SVH
`define ECN_PATH_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define ECNPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECNPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ecnpv_pkg.sv */
// ----------------------------------------------------------------------------
// ecnpv_pkg
// shared types, codes and widths of the ecn path validator
// ----------------------------------------------------------------------------
package ecnpv_pkg;

  localparam int COUNT_WIDTH_DEF = 62;
  localparam int ACK_W           = 62;
  localparam int IN_TDATA_W      = 192;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 72;

  // ecn codepoints
  localparam logic [1:0] CP_NOT_ECT = 2'd0;
  localparam logic [1:0] CP_ECT1    = 2'd1;
  localparam logic [1:0] CP_ECT0    = 2'd2;
  localparam logic [1:0] CP_CE      = 2'd3;

  // event kinds
  localparam logic [1:0] FUNC_SENT    = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_DISABLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAILED  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       sent_cp;
    logic [ACK_W-1:0] ack_ect0;
    logic [ACK_W-1:0] ack_ect1;
    logic [ACK_W-1:0] ack_ce;
    logic [ACK_W:0]   ack_sum01;
  } in_word_t;

  typedef struct packed {
    logic             testing;
    logic             capable;
    logic [ACK_W-1:0] new_ce;
    logic [1:0]       status;
    logic [1:0]       marking;
  } out_word_t;

endpackage

/* rtl/ecnpv_in_stage.sv */
// ----------------------------------------------------------------------------
// ecnpv_in_stage
// input register; unpacks the word and forms the partial ack sum
// ----------------------------------------------------------------------------
module ecnpv_in_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ecnpv_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [ecnpv_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  output logic                            word_valid,
  input  logic                            word_take,
  output ecnpv_pkg::in_word_t             word
);
  import ecnpv_pkg::*;

  in_word_t load_word;

  // nothing is taken while reset is held
  assign s_axis_tready = !rst && (!word_valid || word_take);

  always_comb begin
    load_word.func      = s_axis_tuser;
    load_word.sent_cp   = s_axis_tdata[1:0];
    load_word.ack_ect0  = s_axis_tdata[63:2];
    load_word.ack_ect1  = s_axis_tdata[125:64];
    load_word.ack_ce    = s_axis_tdata[187:126];
    load_word.ack_sum01 = {1'b0, s_axis_tdata[63:2]} + {1'b0, s_axis_tdata[125:64]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (s_axis_tready) begin
      word_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      word <= load_word;
    end
  end

endmodule

/* rtl/ecnpv_core.sv */
// ----------------------------------------------------------------------------
// ecnpv_core
// validation state, per-event update and the result register
// ----------------------------------------------------------------------------
module ecnpv_core #(
  parameter int COUNT_WIDTH = ecnpv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_wdata,
  input  logic                             word_valid,
  output logic                             word_take,
  input  ecnpv_pkg::in_word_t              word,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ecnpv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ecnpv_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [ACK_W-1:0] CNT_MAX = ACK_W'((64'd1 << CW) - 64'd1);

  logic [1:0]    ect_codepoint;
  logic [CW-1:0] tx_ect0, tx_ect0_next;
  logic [CW-1:0] tx_ect1, tx_ect1_next;
  logic [CW:0]   sent_total, sent_total_next;
  logic [CW-1:0] rx_ect0, rx_ect0_next;
  logic [CW-1:0] rx_ect1, rx_ect1_next;
  logic [CW-1:0] rx_ce, rx_ce_next;
  logic          testing, testing_next;
  logic          capable, capable_next;
  logic          failed, failed_next;

  out_word_t     res, out_word;
  logic          bad_count;
  logic [63:0]   acked_total;

  assign word_take = word_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ect_codepoint <= CP_ECT0;
    end else if (cfg_we && (cfg_wdata == CP_ECT0 || cfg_wdata == CP_ECT1)) begin
      ect_codepoint <= cfg_wdata;
    end
  end

  always_comb begin
    bad_count = word.ack_ect0 > CNT_MAX || word.ack_ect1 > CNT_MAX ||
                word.ack_ce > CNT_MAX ||
                word.ack_ect0 < ACK_W'(rx_ect0) ||
                word.ack_ect1 < ACK_W'(rx_ect1) ||
                word.ack_ce < ACK_W'(rx_ce);
    acked_total = {1'b0, word.ack_sum01} + {2'b0, word.ack_ce};
  end

  always_comb begin
    tx_ect0_next    = tx_ect0;
    tx_ect1_next    = tx_ect1;
    sent_total_next = sent_total;
    rx_ect0_next    = rx_ect0;
    rx_ect1_next    = rx_ect1;
    rx_ce_next      = rx_ce;
    testing_next    = testing;
    capable_next    = capable;
    failed_next     = failed;
    res.status      = ST_OK;
    res.new_ce      = '0;
    case (word.func)
      FUNC_SENT: begin
        // saturating counters; the running total tracks real increments only
        if (word.sent_cp == CP_ECT0 && tx_ect0 != '1) begin
          tx_ect0_next    = tx_ect0 + 1'b1;
          sent_total_next = sent_total + 1'b1;
        end else if (word.sent_cp == CP_ECT1 && tx_ect1 != '1) begin
          tx_ect1_next    = tx_ect1 + 1'b1;
          sent_total_next = sent_total + 1'b1;
        end
      end
      FUNC_ACK: begin
        if (failed) begin
          res.status = ST_IGNORED;
        end else if (bad_count || acked_total > 64'(sent_total)) begin
          failed_next  = 1'b1;
          testing_next = 1'b0;
          capable_next = 1'b0;
          res.status   = ST_FAILED;
        end else begin
          res.new_ce   = word.ack_ce - ACK_W'(rx_ce);
          rx_ect0_next = word.ack_ect0[CW-1:0];
          rx_ect1_next = word.ack_ect1[CW-1:0];
          rx_ce_next   = word.ack_ce[CW-1:0];
          if (testing && acked_total != 64'd0) begin
            capable_next = 1'b1;
            testing_next = 1'b0;
          end
        end
      end
      FUNC_DISABLE: begin
        failed_next  = 1'b1;
        testing_next = 1'b0;
        capable_next = 1'b0;
      end
      default: begin
      end
    endcase
    res.marking = (!failed_next && (capable_next || testing_next)) ? ect_codepoint
                                                                   : CP_NOT_ECT;
    res.capable = capable_next && !failed_next;
    res.testing = testing_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_ect0       <= '0;
      tx_ect1       <= '0;
      sent_total    <= '0;
      rx_ect0       <= '0;
      rx_ect1       <= '0;
      rx_ce         <= '0;
      testing       <= 1'b1;
      capable       <= 1'b0;
      failed        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (word_take) begin
        tx_ect0    <= tx_ect0_next;
        tx_ect1    <= tx_ect1_next;
        sent_total <= sent_total_next;
        rx_ect0    <= rx_ect0_next;
        rx_ect1    <= rx_ect1_next;
        rx_ce      <= rx_ce_next;
        testing    <= testing_next;
        capable    <= capable_next;
        failed     <= failed_next;
      end
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= word_take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {4'b0, out_word};

endmodule

/* rtl/ecn_path_validator.sv */
// ----------------------------------------------------------------------------
// ecn_path_validator
// per-path ecn validation: sent counting, ack count checks, failure tracking
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one event per word; tuser holds the event kind
//   (sent, ack, disable) and tdata the sent codepoint and the peer's
//   cumulative ect0, ect1 and ce counts. m_axis returns one result word per
//   event: outgoing marking, status, new ce count and the capable and
//   testing flags, all taken after the event's update.
//   cfg_we / cfg_wdata set the codepoint used on outgoing packets; values
//   other than ect(0) and ect(1) are dropped. write only while idle.
//   an accepted word passes through one input register, then the check and
//   state update feeding the result register. throughput is one event per
//   cycle while results are taken, set by the single state update path;
//   the input register, if empty, accepts a new word while a result waits.
//   when m_axis_tready is low the result register holds, the input register
//   fills, and then s_axis_tready drops until the result is taken.
//   rst (synchronous) clears all counters, returns to testing mode with
//   the path not failed, and sets the codepoint to ect(0).
// ----------------------------------------------------------------------------
module ecn_path_validator #(
  parameter int COUNT_WIDTH = ecnpv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sent_codepoint[1:0], ack_ect0[63:2], ack_ect1[125:64], ack_ce[187:126], zero
  input  logic [ecnpv_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [ecnpv_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // marking[1:0], status[3:2], new_ce[65:4], capable[66], testing[67], zero
  output logic [ecnpv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ecnpv_pkg::*;

  logic     word_valid;
  logic     word_take;
  in_word_t word;

  ecnpv_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .word_valid    (word_valid),
    .word_take     (word_take),
    .word          (word)
  );

  ecnpv_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .word_valid    (word_valid),
    .word_take     (word_take),
    .word          (word),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* rtl/ecnpv_checker.sv */
// ----------------------------------------------------------------------------
// ecnpv_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "ecn_path_validator_defines.svh"

module ecnpv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ecnpv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ecnpv_pkg::*;

  `ECNPV_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // a failing ack leaves the path unmarked and out of both modes
  `ECNPV_ASSERT_NOW(a_fail_clears, m_axis_tvalid && m_axis_tdata[3:2] == ST_FAILED, m_axis_tdata[1:0] == CP_NOT_ECT && !m_axis_tdata[66] && !m_axis_tdata[67], "failed result still marks")

  `ECNPV_ASSERT_NOW(a_modes_excl, m_axis_tvalid, !(m_axis_tdata[66] && m_axis_tdata[67]), "capable and testing both set")

  // ce increase is only reported by an accepted ack
  `ECNPV_ASSERT_NOW(a_ce_ok_only, m_axis_tvalid && m_axis_tdata[3:2] != ST_OK, m_axis_tdata[65:4] == '0, "new ce on rejected ack")

endmodule

bind ecn_path_validator ecnpv_checker u_ecnpv_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
